// ===== hw/rtl/ljfd_pkg.sv =====
// Package for the longest-job-first dispatcher.
// Holds field widths, item kind codes, the entry word and the control/status structs.
// No dependencies.
package ljfd_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int ID_W    = 8;
    localparam int BURST_W = 16;
    localparam int WAIT_W  = 16;
    localparam int AGE_W   = 8;
    localparam int RCNT_W  = 4;

    // item kinds
    localparam logic KIND_ARRIVE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;
    localparam logic [AGE_W-1:0]  AGE_MAX  = '1;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic [WAIT_W-1:0]  wait_cnt;
        logic [AGE_W-1:0]   age;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic start;   // transaction accepted: latch item; on a tick, count down or retire the running job
        logic rd_en;   // read one entry of the sweep
        logic commit;  // apply dispatch or insert, load result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/ljfd_ctrl.sv =====
// Controller for the longest-job-first dispatcher: accept, sweep, drain, commit.
// Depends on ljfd_pkg (t_cmd, t_sts, QUEUE_DEPTH_DEF).
module ljfd_ctrl #(
    parameter int QUEUE_DEPTH = ljfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ljfd_pkg::t_sts                 i_sts,
    output ljfd_pkg::t_cmd                 o_cmd,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_rd_idx
);

    localparam int IW = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_in_ready   = 1'b0;
        o_cmd.start  = 1'b0;
        o_cmd.rd_en  = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_idx       = '0;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                n_idx       = r_idx + 1'b1;
                if (r_idx == IW'(QUEUE_DEPTH - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                // hold until the result register can take the new transaction
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rd_idx = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

// ===== hw/rtl/ljfd_dp.sv =====
// Datapath for the longest-job-first dispatcher: entry memory, valid bits, best-job
// tracker, running-job timer and result register. Depends on ljfd_pkg.
module ljfd_dp #(
    parameter int QUEUE_DEPTH = ljfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ljfd_pkg::t_cmd                      i_cmd,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]      i_rd_idx,
    output ljfd_pkg::t_sts                      o_sts,
    input  logic                                i_kind,
    input  logic [ljfd_pkg::ID_W-1:0]           i_job_id,
    input  logic [ljfd_pkg::BURST_W-1:0]        i_burst,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_dispatched,
    output logic [ljfd_pkg::ID_W-1:0]           o_dispatched_id,
    output logic [ljfd_pkg::WAIT_W-1:0]         o_dispatched_wait,
    output logic                                o_retired,
    output logic                                o_busy_res,
    output logic [ljfd_pkg::RCNT_W-1:0]         o_ready_count,
    output logic                                o_overflow
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    ljfd_pkg::t_entry mem [QUEUE_DEPTH];

    // control state
    logic [QUEUE_DEPTH-1:0]         r_valid;
    logic [CW-1:0]                  r_count;
    logic                           r_running;
    logic [ljfd_pkg::BURST_W-1:0]   r_remaining;
    logic                           r_pv;
    logic                           r_out_vld;

    // item and sweep payload
    logic                           r_kind;
    logic [ljfd_pkg::ID_W-1:0]      r_id;
    logic [ljfd_pkg::BURST_W-1:0]   r_burst;
    logic [IW-1:0]                  r_slot;
    logic                           r_slot_ok;
    logic                           r_ret;
    logic                           r_do_disp;
    logic [IW-1:0]                  r_pidx;
    ljfd_pkg::t_entry               r_rd;
    logic                           r_best_vld;
    logic [IW-1:0]                  r_best_idx;
    logic [ljfd_pkg::BURST_W-1:0]   r_best_burst;
    logic [ljfd_pkg::AGE_W-1:0]     r_best_age;
    logic [ljfd_pkg::ID_W-1:0]      r_best_id;
    logic [ljfd_pkg::WAIT_W-1:0]    r_best_wait;

    // result register
    logic                           r_o_disp;
    logic [ljfd_pkg::ID_W-1:0]      r_o_id;
    logic [ljfd_pkg::WAIT_W-1:0]    r_o_wait;
    logic                           r_o_ret;
    logic                           r_o_busy;
    logic [ljfd_pkg::RCNT_W-1:0]    r_o_cnt;
    logic                           r_o_ovf;

    logic [IW-1:0]                  free_slot;
    logic                           run_keep;
    logic                           proc;
    logic                           better;
    logic                           dispatch_now;
    logic                           insert_now;
    logic [CW-1:0]                  n_count;
    logic [CW+ljfd_pkg::RCNT_W-1:0] count_ext;
    logic                           w_en;
    logic [IW-1:0]                  w_addr;
    ljfd_pkg::t_entry               w_data;

    // lowest free slot of the ready table
    always_comb begin
        free_slot = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = IW'(i);
            end
        end
    end

    assign run_keep = r_running && (r_remaining > ljfd_pkg::BURST_W'(1));
    assign proc     = r_pv && r_valid[r_pidx];
    assign better   = !r_best_vld || (r_rd.burst > r_best_burst) ||
                      ((r_rd.burst == r_best_burst) && (r_rd.age < r_best_age));

    assign dispatch_now = (r_kind == ljfd_pkg::KIND_TICK) && r_do_disp && r_best_vld;
    assign insert_now   = (r_kind == ljfd_pkg::KIND_ARRIVE) && r_slot_ok;

    always_comb begin
        n_count = r_count;
        if (dispatch_now) begin
            n_count = r_count - 1'b1;
        end else if (insert_now) begin
            n_count = r_count + 1'b1;
        end
    end
    assign count_ext = {{ljfd_pkg::RCNT_W{1'b0}}, n_count};

    // single write port: sweep updates, or the new entry at commit
    always_comb begin
        w_en   = 1'b0;
        w_addr = r_pidx;
        w_data = r_rd;
        if (i_cmd.commit) begin
            w_en           = insert_now;
            w_addr         = r_slot;
            w_data.id      = r_id;
            w_data.burst   = r_burst;
            w_data.wait_cnt = '0;
            w_data.age     = '0;
        end else if (proc) begin
            if (r_kind == ljfd_pkg::KIND_TICK) begin
                w_en = 1'b1;
                if (r_rd.wait_cnt != ljfd_pkg::WAIT_MAX) begin
                    w_data.wait_cnt = r_rd.wait_cnt + 1'b1;
                end
            end else if (r_slot_ok) begin
                w_en = 1'b1;
                if (r_rd.age != ljfd_pkg::AGE_MAX) begin
                    w_data.age = r_rd.age + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd <= mem[i_rd_idx];
        end
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
    end

    // item latch, best-job tracker and result register load
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind     <= i_kind;
            r_id       <= i_job_id;
            r_burst    <= i_burst;
            r_slot     <= free_slot;
            r_slot_ok  <= ~&r_valid;
            r_ret      <= (i_kind == ljfd_pkg::KIND_TICK) && r_running && !run_keep;
            r_do_disp  <= (i_kind == ljfd_pkg::KIND_TICK) && !run_keep;
            r_best_vld <= 1'b0;
        end else if (proc && (r_kind == ljfd_pkg::KIND_TICK) && better) begin
            r_best_vld   <= 1'b1;
            r_best_idx   <= r_pidx;
            r_best_burst <= r_rd.burst;
            r_best_age   <= r_rd.age;
            r_best_id    <= r_rd.id;
            r_best_wait  <= r_rd.wait_cnt;
        end
        if (i_cmd.rd_en) begin
            r_pidx <= i_rd_idx;
        end
        if (i_cmd.commit) begin
            r_o_disp <= dispatch_now;
            r_o_id   <= dispatch_now ? r_best_id : '0;
            r_o_wait <= dispatch_now ? r_best_wait : '0;
            r_o_ret  <= (r_kind == ljfd_pkg::KIND_TICK) && r_ret;
            r_o_busy <= dispatch_now || r_running;
            r_o_cnt  <= count_ext[ljfd_pkg::RCNT_W-1:0];
            r_o_ovf  <= (r_kind == ljfd_pkg::KIND_ARRIVE) && !r_slot_ok;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_count     <= '0;
            r_running   <= 1'b0;
            r_remaining <= '0;
            r_pv        <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_pv <= i_cmd.rd_en;
            if (i_cmd.start && (i_kind == ljfd_pkg::KIND_TICK) && r_running) begin
                // retire at one remaining tick or less, else count down
                if (run_keep) begin
                    r_remaining <= r_remaining - 1'b1;
                end else begin
                    r_running   <= 1'b0;
                    r_remaining <= '0;
                end
            end
            if (i_cmd.commit) begin
                r_count <= n_count;
                if (dispatch_now) begin
                    r_running            <= 1'b1;
                    r_remaining          <= r_best_burst;
                    r_valid[r_best_idx]  <= 1'b0;
                end
                if (insert_now) begin
                    r_valid[r_slot] <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.out_free   = !r_out_vld || i_out_ready;
    assign o_out_valid       = r_out_vld;
    assign o_dispatched      = r_o_disp;
    assign o_dispatched_id   = r_o_id;
    assign o_dispatched_wait = r_o_wait;
    assign o_retired         = r_o_ret;
    assign o_busy_res        = r_o_busy;
    assign o_ready_count     = r_o_cnt;
    assign o_overflow        = r_o_ovf;

endmodule

// ===== hw/rtl/longest_job_first_dispatcher_unit.sv =====
// Top level of the longest-job-first dispatcher: controller plus datapath.
// Depends on ljfd_pkg, ljfd_ctrl and ljfd_dp.
//
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------------------
//  in      | i_in_valid / o_in_ready   | i_kind, i_job_id, i_burst
//  out     | o_out_valid / i_out_ready | o_dispatched, o_dispatched_id,
//          |                           | o_dispatched_wait, o_retired, o_busy_res,
//          |                           | o_ready_count, o_overflow
//
// Each transaction passes through the accept state, then the sweep reads
// one entry of the ready-table memory per cycle, then the drain state and the commit state.
// One result per transaction; the result register frees the input side, and the
// commit cycle holds while an earlier result is still not taken.
// Reset (i_rst_n low, synchronous) empties the table and idles the processor.
module longest_job_first_dispatcher_unit #(
    parameter int QUEUE_DEPTH = ljfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_kind,
    input  logic [ljfd_pkg::ID_W-1:0]   i_job_id,
    input  logic [ljfd_pkg::BURST_W-1:0] i_burst,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_dispatched,
    output logic [ljfd_pkg::ID_W-1:0]   o_dispatched_id,
    output logic [ljfd_pkg::WAIT_W-1:0] o_dispatched_wait,
    output logic                        o_retired,
    output logic                        o_busy_res,
    output logic [ljfd_pkg::RCNT_W-1:0] o_ready_count,
    output logic                        o_overflow
);

    ljfd_pkg::t_cmd                 cmd;
    ljfd_pkg::t_sts                 sts;
    logic [$clog2(QUEUE_DEPTH)-1:0] rd_idx;

    ljfd_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_rd_idx   (rd_idx)
    );

    ljfd_dp #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_rd_idx          (rd_idx),
        .o_sts             (sts),
        .i_kind            (i_kind),
        .i_job_id          (i_job_id),
        .i_burst           (i_burst),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_dispatched      (o_dispatched),
        .o_dispatched_id   (o_dispatched_id),
        .o_dispatched_wait (o_dispatched_wait),
        .o_retired         (o_retired),
        .o_busy_res        (o_busy_res),
        .o_ready_count     (o_ready_count),
        .o_overflow        (o_overflow)
    );

endmodule

// ===== bench/ljfd_checker.sv =====
// Scoreboard for the longest-job-first dispatcher: mirrors the ready table and the
// processor, predicts one result per input transaction and checks the output channel.
// Depends on ljfd_pkg.
module ljfd_checker #(
    parameter int QUEUE_DEPTH = ljfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_kind,
    input  logic [ljfd_pkg::ID_W-1:0]      i_job_id,
    input  logic [ljfd_pkg::BURST_W-1:0]   i_burst,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic                           i_dispatched,
    input  logic [ljfd_pkg::ID_W-1:0]      i_dispatched_id,
    input  logic [ljfd_pkg::WAIT_W-1:0]    i_dispatched_wait,
    input  logic                           i_retired,
    input  logic                           i_busy_res,
    input  logic [ljfd_pkg::RCNT_W-1:0]    i_ready_count,
    input  logic                           i_overflow,
    output int                             o_fail_count,
    output int                             o_pending
);

    localparam int ID_W    = ljfd_pkg::ID_W;
    localparam int BURST_W = ljfd_pkg::BURST_W;
    localparam int WAIT_W  = ljfd_pkg::WAIT_W;
    localparam int AGE_W   = ljfd_pkg::AGE_W;
    localparam int RCNT_W  = ljfd_pkg::RCNT_W;

    localparam logic              KIND_ARRIVE = ljfd_pkg::KIND_ARRIVE;
    localparam logic [WAIT_W-1:0] WAIT_MAX    = ljfd_pkg::WAIT_MAX;
    localparam logic [AGE_W-1:0]  AGE_MAX     = ljfd_pkg::AGE_MAX;

    typedef struct packed {
        logic              dispatched;
        logic [ID_W-1:0]   disp_id;
        logic [WAIT_W-1:0] disp_wait;
        logic              retired;
        logic              busy;
        logic [RCNT_W-1:0] ready_cnt;
        logic              overflow;
    } t_outcome;

    // mirror of the ready table and the processor
    logic               slot_used  [QUEUE_DEPTH];
    logic [ID_W-1:0]    slot_id    [QUEUE_DEPTH];
    logic [BURST_W-1:0] slot_burst [QUEUE_DEPTH];
    logic [WAIT_W-1:0]  slot_wait  [QUEUE_DEPTH];
    logic [AGE_W-1:0]   slot_age   [QUEUE_DEPTH];
    logic               cpu_busy;
    logic [BURST_W-1:0] cpu_left;

    t_outcome outcome_q[$];
    int       fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    function automatic t_outcome advance_scheduler(input logic kind,
                                                   input logic [ID_W-1:0] id,
                                                   input logic [BURST_W-1:0] burst);
        t_outcome r;
        int       free_slot;
        int       pick;
        int       n;
        r         = '0;
        free_slot = -1;
        pick      = -1;
        n         = 0;
        if (kind == KIND_ARRIVE) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (!slot_used[i] && free_slot < 0) free_slot = i;
            end
            if (free_slot < 0) begin
                r.overflow = 1'b1;
            end else begin
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    if (slot_used[i] && slot_age[i] != AGE_MAX) slot_age[i]++;
                end
                slot_used[free_slot]  = 1'b1;
                slot_id[free_slot]    = id;
                slot_burst[free_slot] = burst;
                slot_wait[free_slot]  = '0;
                slot_age[free_slot]   = '0;
            end
        end else begin
            // a zero burst retires on the next tick, like a burst of one
            if (cpu_busy) begin
                if (cpu_left <= 1) begin
                    cpu_busy  = 1'b0;
                    cpu_left  = '0;
                    r.retired = 1'b1;
                end else begin
                    cpu_left--;
                end
            end
            if (!cpu_busy) begin
                // largest burst wins, the youngest entry breaks a tie
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    if (slot_used[i]) begin
                        if (pick < 0 || slot_burst[i] > slot_burst[pick] ||
                            (slot_burst[i] == slot_burst[pick] &&
                             slot_age[i] < slot_age[pick]))
                            pick = i;
                    end
                end
                if (pick >= 0) begin
                    r.dispatched    = 1'b1;
                    r.disp_id       = slot_id[pick];
                    r.disp_wait     = slot_wait[pick];
                    cpu_busy        = 1'b1;
                    cpu_left        = slot_burst[pick];
                    slot_used[pick] = 1'b0;
                end
            end
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (slot_used[i] && slot_wait[i] != WAIT_MAX) slot_wait[i]++;
            end
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) n += int'(slot_used[i]);
        r.busy      = cpu_busy;
        r.ready_cnt = RCNT_W'(n);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                slot_used[i]  = 1'b0;
                slot_id[i]    = '0;
                slot_burst[i] = '0;
                slot_wait[i]  = '0;
                slot_age[i]   = '0;
            end
            cpu_busy = 1'b0;
            cpu_left = '0;
            outcome_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result transaction with no input transaction outstanding");
                    fail_cnt++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("dispatched", want.dispatched, i_dispatched);
                    check_field("dispatched_id", want.disp_id, i_dispatched_id);
                    check_field("dispatched_wait", want.disp_wait, i_dispatched_wait);
                    check_field("retired", want.retired, i_retired);
                    check_field("busy_res", want.busy, i_busy_res);
                    check_field("ready_count", want.ready_cnt, i_ready_count);
                    check_field("overflow", want.overflow, i_overflow);
                end
            end
            if (i_in_valid && i_in_ready)
                outcome_q.push_back(advance_scheduler(i_kind, i_job_id, i_burst));
        end
        o_pending <= outcome_q.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the longest-job-first dispatcher: clock, reset, arrival and tick
// traffic, a randomly stalling receiver, watchdog and verdict.
// Depends on ljfd_pkg, longest_job_first_dispatcher_unit and ljfd_checker.
module tb_top;

    localparam int QUEUE_DEPTH  = ljfd_pkg::QUEUE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1600;
    localparam int QUIET_ITEMS  = 200;
    localparam int HOLD_AT      = 600;
    localparam int LONG_HOLD    = 400;
    localparam int STUCK_LIMIT  = 2000;

    localparam int ID_W    = ljfd_pkg::ID_W;
    localparam int BURST_W = ljfd_pkg::BURST_W;
    localparam int WAIT_W  = ljfd_pkg::WAIT_W;
    localparam int RCNT_W  = ljfd_pkg::RCNT_W;

    localparam logic KIND_ARRIVE = ljfd_pkg::KIND_ARRIVE;
    localparam logic KIND_TICK   = ljfd_pkg::KIND_TICK;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic               i_kind       = KIND_TICK;
    logic [ID_W-1:0]    i_job_id     = '0;
    logic [BURST_W-1:0] i_burst      = '0;
    logic               i_out_ready  = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_dispatched;
    logic [ID_W-1:0]    o_dispatched_id;
    logic [WAIT_W-1:0]  o_dispatched_wait;
    logic               o_retired;
    logic               o_busy_res;
    logic [RCNT_W-1:0]  o_ready_count;
    logic               o_overflow;

    int          fail_count;
    int          pending;
    int          items_sent   = 0;
    bit          tail_phase   = 1'b0;
    bit          rx_holding   = 1'b0;
    int unsigned stuck_cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    longest_job_first_dispatcher_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_job_id         (i_job_id),
        .i_burst          (i_burst),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_dispatched     (o_dispatched),
        .o_dispatched_id  (o_dispatched_id),
        .o_dispatched_wait(o_dispatched_wait),
        .o_retired        (o_retired),
        .o_busy_res       (o_busy_res),
        .o_ready_count    (o_ready_count),
        .o_overflow       (o_overflow)
    );

    ljfd_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_job_id         (i_job_id),
        .i_burst          (i_burst),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_dispatched     (o_dispatched),
        .i_dispatched_id  (o_dispatched_id),
        .i_dispatched_wait(o_dispatched_wait),
        .i_retired        (o_retired),
        .i_busy_res       (o_busy_res),
        .i_ready_count    (o_ready_count),
        .i_overflow       (o_overflow),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // hold the payload until the transaction goes through
    task automatic offer_item(input logic kind, input logic [ID_W-1:0] id,
                              input logic [BURST_W-1:0] burst);
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_job_id   <= id;
        i_burst    <= burst;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // receiver: random stalls, one long hold-off, no stalls in the tail
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_done && items_sent >= HOLD_AT) begin
                hold_done   = 1'b1;
                rx_holding  = 1'b1;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                rx_holding  = 1'b0;
            end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    // drop the run if nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $error("no transaction for %0d cycles", STUCK_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int               left;
        int               seg_len;
        int               arrive_pct;
        bit               gaps_on;
        logic [BURST_W-1:0] burst;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // tick on an empty table, ignored fields at their top values
        offer_item(KIND_TICK, 8'hFF, 16'hFFFF);
        // zero burst: dispatch, then retire on the very next tick
        offer_item(KIND_ARRIVE, 8'h00, 16'h0000);
        offer_item(KIND_TICK, 8'h00, 16'h0000);
        offer_item(KIND_TICK, 8'hA5, 16'h5A5A);
        // equal bursts: the later arrival goes first
        offer_item(KIND_ARRIVE, 8'hFF, 16'h0001);
        offer_item(KIND_ARRIVE, 8'h5A, 16'h0003);
        offer_item(KIND_ARRIVE, 8'hA5, 16'h0003);
        offer_item(KIND_TICK, 8'h00, 16'h0000);
        // fill the table, then overflow it
        for (int k = 1; k <= 6; k++) offer_item(KIND_ARRIVE, ID_W'(k), 16'h0002);
        offer_item(KIND_ARRIVE, 8'hFF, 16'hFFFF);
        offer_item(KIND_ARRIVE, 8'h00, 16'h0000);
        repeat (4) offer_item(KIND_TICK, 8'h00, 16'hFFFF);

        left = RANDOM_ITEMS;
        while (left > 0) begin
            seg_len = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
                0: arrive_pct = 15;
                1: arrive_pct = 40;
                default: arrive_pct = 70;
            endcase
            gaps_on = ($urandom_range(0, 2) != 0);
            for (int k = 0; k < seg_len && left > 0; k++) begin
                if (left <= QUIET_ITEMS) tail_phase = 1'b1;
                if (gaps_on && !tail_phase && !rx_holding && $urandom_range(0, 3) == 0)
                    pause_sender($urandom_range(1, 12));
                if ($urandom_range(0, 99) < arrive_pct) begin
                    // mostly short jobs, so ties and retirements come often
                    case ($urandom_range(0, 19))
                        0:        burst = BURST_W'($urandom_range(9, 40));
                        1, 2, 3:  burst = BURST_W'($urandom_range(3, 8));
                        default:  burst = BURST_W'($urandom_range(0, 2));
                    endcase
                    offer_item(KIND_ARRIVE, ID_W'($urandom_range(0, 255)), burst);
                end else begin
                    offer_item(KIND_TICK, ID_W'($urandom), BURST_W'($urandom));
                end
                left--;
            end
        end

        // long jobs last, so they cannot hold the processor for the whole run
        repeat (12) offer_item(KIND_TICK, ID_W'($urandom), BURST_W'($urandom));
        offer_item(KIND_ARRIVE, ID_W'($urandom), 16'hFFFF);
        offer_item(KIND_ARRIVE, ID_W'($urandom), 16'h8000);
        offer_item(KIND_ARRIVE, ID_W'($urandom), 16'hAAAA);
        offer_item(KIND_ARRIVE, ID_W'($urandom), 16'h5555);
        repeat (6) offer_item(KIND_TICK, ID_W'($urandom), BURST_W'($urandom));

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (3 * (QUEUE_DEPTH + 3)) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
